// ----- design/dpbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpbp_pkg: shared definitions for the depth pixel back-projection block
// Holds the register indexes, fixed widths, constants and the pipeline
// stage payload types and the round_sat rounding function.
// ----------------------------------------------------------------------------
package dpbp_pkg;

  // Number of low bits of a pixel position that take part in the projection.
  localparam int COORD_BITS = 12;

  localparam int POS_W   = 12;  // pixel_col / pixel_row port width
  localparam int CTR_W   = 24;  // center registers, Q16.8
  localparam int MAG_W   = 24;  // |pos*256 - center|
  localparam int DEPTH_W = 32;  // Q16.16 metres
  localparam int PROD_W  = MAG_W + DEPTH_W;  // 56
  localparam int HI_W    = PROD_W - 32;      // 24
  localparam int MID_W   = HI_W + 32 + 1;    // 57
  localparam int CFG_IDX_W = 3;

  localparam logic [POS_W-1:0] COORD_MASK = POS_W'((1 << COORD_BITS) - 1);

  // Millimetre to Q16.16 metre conversion: floor(n / 1000) with
  // n = mm * 65536 + 500 is taken as (n * MM_RECIP) >> MM_SHIFT.
  localparam int MM_SHIFT = 38;
  localparam int MM_RECIP_W = 29;
  localparam logic [MM_RECIP_W-1:0] MM_RECIP = 29'd274877907;
  localparam logic [31:0] MM_ROUND = 32'd500;
  localparam int MM_PROD_W = 32 + MM_RECIP_W;  // 61
  localparam int MM_Q_W = MM_PROD_W - MM_SHIFT;  // 23

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_FORMAT = 3'd0,
    CFG_COLOR_MODE   = 3'd1,
    CFG_INV_FOCAL_X  = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4,
    CFG_DEPTH_LIMIT  = 3'd5
  } cfg_index_t;

  localparam logic        FMT_MM   = 1'b0;
  localparam logic        MODE_GRAY = 1'b0;

  localparam logic [31:0] RST_INV_FOCAL_X = 32'd8589935;
  localparam logic [23:0] RST_CENTER_X    = 24'd81920;
  localparam logic [23:0] RST_CENTER_Y    = 24'd61440;
  localparam logic [31:0] RST_DEPTH_LIMIT = 32'd655360;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [MAG_W-1:0]     x_mag;
    logic                 x_neg;
    logic [MAG_W-1:0]     y_mag;
    logic                 y_neg;
    logic [31:0]          raw;
    logic [MM_PROD_W-1:0] mm_prod;
    logic                 fmt;
    logic                 finite_ok;
    rgb_t                 rgb;
  } st1_t;

  typedef struct packed {
    logic [MAG_W-1:0]   x_mag;
    logic               x_neg;
    logic [MAG_W-1:0]   y_mag;
    logic               y_neg;
    logic [DEPTH_W-1:0] depth;
    logic               ok;
    rgb_t               rgb;
  } st2_t;

  typedef struct packed {
    logic [PROD_W-1:0]  x_prod;
    logic               x_neg;
    logic [PROD_W-1:0]  y_prod;
    logic               y_neg;
    logic [DEPTH_W-1:0] depth;
    logic               ok;
    rgb_t               rgb;
  } st3_t;

  typedef struct packed {
    logic [63:0]        x_lo;
    logic [HI_W+31:0]   x_hi;
    logic               x_neg;
    logic [63:0]        y_lo;
    logic [HI_W+31:0]   y_hi;
    logic               y_neg;
    logic [DEPTH_W-1:0] depth;
    logic               ok;
    rgb_t               rgb;
  } st4_t;

  // Round a Q.24 magnitude (already shifted down by 32) to Q16.16 with
  // ties away from zero, apply the sign and saturate to the int32 range.
  function automatic logic [31:0] round_sat(input logic [MID_W-1:0] mid,
                                            input logic neg);
    logic [MID_W:0]   sum;
    logic [MID_W-8:0] mag;
    logic [31:0]      res;
    sum = {1'b0, mid} + (MID_W+1)'(128);
    mag = sum[MID_W:8];
    if (neg) begin
      if (mag > (MID_W-7)'(33'h0_8000_0000)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > (MID_W-7)'(33'h0_7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[31:0];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/depth_pixel_back_projection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_back_projection: pinhole back-projection of one depth pixel
// Turns a depth pixel with its column, row and colour into one coloured
// 3-D point in signed Q16.16 metres, using a preloaded reciprocal focal
// length, principal point and depth limit.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  input    in_valid / in_ready   pixel_col, pixel_row, depth_raw, depth_finite,
//                                 pix_blue, pix_green, pix_red
//  output   out_valid / out_ready point_x, point_y, point_z, point_valid,
//                                 out_red, out_green, out_blue
//  config   cfg_wr_en             cfg_index, cfg_wdata (write only, no wait)
//
// One request enters per clock while the output does not stall, with one
// stage each for the millimetre conversion, the depth range check, magnitude
// times depth, times the reciprocal (a low 32x32 and a high 24x32 partial
// product), and the final rounding and saturation.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stall at the output only fills bubbles and
// never drops or repeats a request.
// Reset (rst, synchronous) clears every valid bit and loads the default
// camera parameters; in_ready stays low while reset is held.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [dpbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_wdata,
  // input pixel requests
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [dpbp_pkg::POS_W-1:0]     pixel_col,
  input  wire logic [dpbp_pkg::POS_W-1:0]     pixel_row,
  input  wire logic [31:0]                    depth_raw,
  input  wire logic                           depth_finite,
  input  wire logic [7:0]                     pix_blue,
  input  wire logic [7:0]                     pix_green,
  input  wire logic [7:0]                     pix_red,
  // output point requests
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [31:0]             point_x,
  output      logic signed [31:0]             point_y,
  output      logic [31:0]                    point_z,
  output      logic                           point_valid,
  output      logic [7:0]                     out_red,
  output      logic [7:0]                     out_green,
  output      logic [7:0]                     out_blue
);
  import dpbp_pkg::*;

  // Configuration registers.
  logic              depth_format;
  logic              color_mode;
  logic [31:0]       inv_focal_x;
  logic [CTR_W-1:0]  center_x;
  logic [CTR_W-1:0]  center_y;
  logic [31:0]       depth_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_format <= FMT_MM;
      color_mode   <= MODE_GRAY;
      inv_focal_x  <= RST_INV_FOCAL_X;
      center_x     <= RST_CENTER_X;
      center_y     <= RST_CENTER_Y;
      depth_limit  <= RST_DEPTH_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEPTH_FORMAT: depth_format <= cfg_wdata[0];
        CFG_COLOR_MODE:   color_mode   <= cfg_wdata[0];
        CFG_INV_FOCAL_X:  inv_focal_x  <= cfg_wdata;
        CFG_CENTER_X:     center_x     <= cfg_wdata[CTR_W-1:0];
        CFG_CENTER_Y:     center_y     <= cfg_wdata[CTR_W-1:0];
        CFG_DEPTH_LIMIT:  depth_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and load enables. A stage loads when it is empty
  // or when its contents move on in the same cycle.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  // No request is taken while reset is held, since it would be dropped.
  assign in_ready  = en1 && !rst;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: signed offsets of the pixel from the principal point, the
  // millimetre conversion multiply and the colour selection.
  st1_t s1, s1_next;
  logic [MAG_W-1:0] col_q8, row_q8;
  logic [31:0]      mm_num;

  always_comb begin
    col_q8 = MAG_W'(pixel_col & COORD_MASK) << 8;
    row_q8 = MAG_W'(pixel_row & COORD_MASK) << 8;
    s1_next.x_neg = col_q8 < center_x;
    s1_next.x_mag = s1_next.x_neg ? (center_x - col_q8) : (col_q8 - center_x);
    s1_next.y_neg = row_q8 < center_y;
    s1_next.y_mag = s1_next.y_neg ? (center_y - row_q8) : (row_q8 - center_y);
    // Round to nearest with ties up: add half of the divisor first.
    mm_num = {depth_raw[15:0], 16'd0} + MM_ROUND;
    s1_next.mm_prod = MM_PROD_W'(mm_num) * MM_PROD_W'(MM_RECIP);
    s1_next.raw = depth_raw;
    s1_next.fmt = depth_format;
    // An integer millimetre sample is always finite.
    s1_next.finite_ok = (depth_format == FMT_MM) ? 1'b1 : depth_finite;
    if (color_mode == MODE_GRAY) begin
      s1_next.rgb.red   = pix_blue;
      s1_next.rgb.green = pix_blue;
    end else begin
      s1_next.rgb.red   = pix_red;
      s1_next.rgb.green = pix_green;
    end
    s1_next.rgb.blue = pix_blue;
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
  end

  // Stage 2: final depth in Q16.16 metres and the range check.
  st2_t s2, s2_next;

  always_comb begin
    s2_next.x_mag = s1.x_mag;
    s2_next.x_neg = s1.x_neg;
    s2_next.y_mag = s1.y_mag;
    s2_next.y_neg = s1.y_neg;
    s2_next.rgb   = s1.rgb;
    if (s1.fmt == FMT_MM) begin
      s2_next.depth = DEPTH_W'(s1.mm_prod[MM_PROD_W-1:MM_SHIFT]);
    end else begin
      s2_next.depth = s1.raw;
    end
    s2_next.ok = s1.finite_ok && (s2_next.depth < depth_limit);
  end

  always_ff @(posedge clk) begin
    if (en2) s2 <= s2_next;
  end

  // Stage 3: offset magnitude times depth, exact 56-bit products.
  st3_t s3, s3_next;

  always_comb begin
    s3_next.x_prod = PROD_W'(s2.x_mag) * PROD_W'(s2.depth);
    s3_next.y_prod = PROD_W'(s2.y_mag) * PROD_W'(s2.depth);
    s3_next.x_neg  = s2.x_neg;
    s3_next.y_neg  = s2.y_neg;
    s3_next.depth  = s2.depth;
    s3_next.ok     = s2.ok;
    s3_next.rgb    = s2.rgb;
  end

  always_ff @(posedge clk) begin
    if (en3) s3 <= s3_next;
  end

  // Stage 4: times the reciprocal focal length, as a low 32x32 and a high
  // 24x32 partial product per axis.
  st4_t s4, s4_next;

  always_comb begin
    s4_next.x_lo  = 64'(s3.x_prod[31:0]) * 64'(inv_focal_x);
    s4_next.x_hi  = (HI_W+32)'(s3.x_prod[PROD_W-1:32]) * (HI_W+32)'(inv_focal_x);
    s4_next.y_lo  = 64'(s3.y_prod[31:0]) * 64'(inv_focal_x);
    s4_next.y_hi  = (HI_W+32)'(s3.y_prod[PROD_W-1:32]) * (HI_W+32)'(inv_focal_x);
    s4_next.x_neg = s3.x_neg;
    s4_next.y_neg = s3.y_neg;
    s4_next.depth = s3.depth;
    s4_next.ok    = s3.ok;
    s4_next.rgb   = s3.rgb;
  end

  always_ff @(posedge clk) begin
    if (en4) s4 <= s4_next;
  end

  // Stage 5: combine the partial products, round, saturate and register
  // the result. Rejected points give zero coordinates but keep colour.
  logic [MID_W-1:0] x_mid, y_mid;
  logic [31:0]      x_res, y_res;

  always_comb begin
    x_mid = MID_W'(s4.x_hi) + MID_W'(s4.x_lo[63:32]);
    y_mid = MID_W'(s4.y_hi) + MID_W'(s4.y_lo[63:32]);
    x_res = round_sat(x_mid, s4.x_neg);
    y_res = round_sat(y_mid, s4.y_neg);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      point_x     <= s4.ok ? x_res : 32'd0;
      point_y     <= s4.ok ? y_res : 32'd0;
      point_z     <= s4.ok ? s4.depth : 32'd0;
      point_valid <= s4.ok;
      out_red     <= s4.rgb.red;
      out_green   <= s4.rgb.green;
      out_blue    <= s4.rgb.blue;
    end
  end

endmodule
`default_nettype wire
